/* rtl/ekmf_pkg.sv */
package ekmf_pkg;

  localparam int MAX_NODES_DEF = 1024;
  localparam int MAX_EDGES_DEF = 4096;
  localparam int CAP_WIDTH_DEF = 16;

  localparam int NODE_W = 10;
  localparam int FLOW_W = 28;
  localparam logic [FLOW_W-1:0] FLOW_LIMIT = 28'hFFF_FFFF;

  localparam logic [1:0] ACT_CLEAR   = 2'd0;
  localparam logic [1:0] ACT_ADD     = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  localparam logic [1:0] CFG_SOURCE = 2'd0;
  localparam logic [1:0] CFG_SINK   = 2'd1;
  localparam logic [1:0] CFG_NODES  = 2'd2;

endpackage

/* rtl/edmonds_karp_max_flow.sv */
// Channel | Ports                                              | Direction
// in      | in_valid/in_ready, in_action, in_tail_node,        | request in
//         | in_head_node, in_capacity                          |
// out     | out_valid/out_ready, out_max_flow,                 | result out
//         | out_edges_dropped                                  |
// cfg     | cfg_write_en, cfg_index, cfg_data                  | register write
//
// Clear and add-edge requests keep in_ready high and produce no result.
// A compute request holds in_ready low through the table build and then, per
//   search, clearing the visited flags, dequeuing nodes, scanning their arcs
//   and walking each augmenting path twice; each step makes at most one access
//   per work memory.
// Synchronous reset (rst_n low) clears edge count, flags, control; sets source 0,
// sink 1, 1024 nodes; memories need no clearing pass. A pending result holds until taken.
module edmonds_karp_max_flow #(
  parameter int MAX_NODES = ekmf_pkg::MAX_NODES_DEF,
  parameter int MAX_EDGES = ekmf_pkg::MAX_EDGES_DEF,
  parameter int CAP_WIDTH = ekmf_pkg::CAP_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_action,
  input  logic [ekmf_pkg::NODE_W-1:0] in_tail_node,
  input  logic [ekmf_pkg::NODE_W-1:0] in_head_node,
  input  logic [15:0]                 in_capacity,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ekmf_pkg::FLOW_W-1:0] out_max_flow,
  output logic                        out_edges_dropped,
  input  logic                        cfg_write_en,
  input  logic [1:0]                  cfg_index,
  input  logic [10:0]                 cfg_data
);

  localparam int NW   = ekmf_pkg::NODE_W;
  localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;   // edge address
  localparam int ECW  = $clog2(MAX_EDGES + 1);                     // edge count
  localparam int ARW  = $clog2(2 * MAX_EDGES);                     // arc id
  localparam int SW   = $clog2(2 * MAX_EDGES + 1);                 // adjacency slot
  localparam int NAW  = $clog2(MAX_NODES);                         // node address
  localparam int FAW  = $clog2(MAX_NODES + 1);                     // slot table address
  localparam int TW   = ((CAP_WIDTH > ekmf_pkg::FLOW_W) ? CAP_WIDTH : ekmf_pkg::FLOW_W) + 1;

  // sequencer codes
  localparam logic [4:0] S_IDLE = 5'd0,  S_CHK  = 5'd1,  S_FCLR = 5'd2,  S_CRD  = 5'd3;
  localparam logic [4:0] S_CUS  = 5'd4,  S_CWR  = 5'd5,  S_PRD  = 5'd6,  S_PWR  = 5'd7;
  localparam logic [4:0] S_LRD  = 5'd8,  S_LUS  = 5'd9,  S_LWR  = 5'd10, S_SRD  = 5'd11;
  localparam logic [4:0] S_SWR  = 5'd12, S_SZ   = 5'd13, S_BCLR = 5'd14, S_BINI = 5'd15;
  localparam logic [4:0] S_BDEQ = 5'd16, S_BU   = 5'd17, S_BB   = 5'd18, S_BE   = 5'd19;
  localparam logic [4:0] S_BADJ = 5'd20, S_BARC = 5'd21, S_BEV  = 5'd22, S_BCHK = 5'd23;
  localparam logic [4:0] S_P1R  = 5'd24, S_P1E  = 5'd25, S_P1C  = 5'd26, S_P2R  = 5'd27;
  localparam logic [4:0] S_P2E  = 5'd28, S_P2W  = 5'd29, S_FIN  = 5'd30;

  // memories
  logic [NW-1:0]        etail_mem [MAX_EDGES];
  logic [NW-1:0]        ehead_mem [MAX_EDGES];
  logic [CAP_WIDTH-1:0] ecap_mem  [MAX_EDGES];
  logic [CAP_WIDTH-1:0] eflow_mem [MAX_EDGES];
  logic [ARW-1:0]       adj_mem   [2*MAX_EDGES];
  logic [SW-1:0]        first_mem [MAX_NODES+1];
  logic [ARW-1:0]       par_mem   [MAX_NODES];
  logic [NW-1:0]        queue_mem [MAX_NODES];
  logic                 seen_mem  [MAX_NODES];

  // memory ports
  logic                 e_we, fl_we, a_we, f_we, p_we, q_we, r_we;
  logic [EAW-1:0]       e_wa, e_ra, fl_wa;
  logic [CAP_WIDTH-1:0] fl_wd;
  logic [ARW-1:0]       a_wa, a_wd, a_ra, p_wd;
  logic [FAW-1:0]       f_wa, f_ra;
  logic [SW-1:0]        f_wd;
  logic [NAW-1:0]       p_wa, p_ra, q_wa, q_ra, r_wa, r_ra;
  logic [NW-1:0]        q_wd;
  logic                 r_wd;

  logic [NW-1:0]        e_tail_rd_r, e_head_rd_r, q_rd_r;
  logic [CAP_WIDTH-1:0] e_cap_rd_r, e_flow_rd_r;
  logic [ARW-1:0]       a_rd_r, p_rd_r;
  logic [SW-1:0]        f_rd_r;
  logic                 r_rd_r;

  always_ff @(posedge clk) begin
    if (e_we) begin
      etail_mem[e_wa] <= in_tail_node;
      ehead_mem[e_wa] <= in_head_node;
      ecap_mem[e_wa]  <= CAP_WIDTH'(in_capacity);
    end
    if (fl_we) eflow_mem[fl_wa] <= fl_wd;
    if (a_we)  adj_mem[a_wa]    <= a_wd;
    if (f_we)  first_mem[f_wa]  <= f_wd;
    if (p_we)  par_mem[p_wa]    <= p_wd;
    if (q_we)  queue_mem[q_wa]  <= q_wd;
    if (r_we)  seen_mem[r_wa]   <= r_wd;
    e_tail_rd_r <= etail_mem[e_ra];
    e_head_rd_r <= ehead_mem[e_ra];
    e_cap_rd_r  <= ecap_mem[e_ra];
    e_flow_rd_r <= eflow_mem[e_ra];
    a_rd_r      <= adj_mem[a_ra];
    f_rd_r      <= first_mem[f_ra];
    p_rd_r      <= par_mem[p_ra];
    q_rd_r      <= queue_mem[q_ra];
    r_rd_r      <= seen_mem[r_ra];
  end

  // control and working registers
  logic [4:0]                  state_r, state_nxt;
  logic [NW-1:0]               src_r, src_nxt, dst_r, dst_nxt;
  logic [10:0]                 ncfg_r, ncfg_nxt;
  logic [FAW-1:0]              nodes_r, nodes_nxt, v_r, v_nxt;
  logic [ECW-1:0]              ecnt_r, ecnt_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [ARW:0]                id_r, id_nxt;
  logic [NW-1:0]               from_r, from_nxt, u_r, u_nxt, to_r, to_nxt;
  logic [SW-1:0]               sum_r, sum_nxt, k_r, k_nxt, kend_r, kend_nxt;
  logic [FAW-1:0]              qh_r, qh_nxt, qt_r, qt_nxt;
  logic [ARW-1:0]              arc_r, arc_nxt;
  logic                        resnz_r, resnz_nxt;
  logic [CAP_WIDTH-1:0]        delta_r, delta_nxt;
  logic [ekmf_pkg::FLOW_W-1:0] total_r, total_nxt;
  logic                        ov_r, ov_nxt;
  logic [ekmf_pkg::FLOW_W-1:0] of_r, of_nxt;
  logic                        od_r, od_nxt;

  function automatic logic [EAW-1:0] eidx(input logic [ARW-1:0] id, input logic [ECW-1:0] e);
    logic [ARW:0] w;
    w = ((ARW+1)'(id) >= (ARW+1)'(e)) ? (ARW+1)'(id) - (ARW+1)'(e) : (ARW+1)'(id);
    return w[EAW-1:0];
  endfunction

  logic [ARW:0]         arcs;
  logic                 rev;
  logic                 usable;
  logic [NW-1:0]        arc_from, arc_to;
  logic [CAP_WIDTH-1:0] resid;
  logic [TW-1:0]        tsum;

  always_comb begin
    arcs     = (ARW+1)'(ecnt_r) + (ARW+1)'(ecnt_r);
    rev      = (ARW+1)'(arc_r) >= (ARW+1)'(ecnt_r);
    usable   = (32'(e_tail_rd_r) < 32'(nodes_r)) && (32'(e_head_rd_r) < 32'(nodes_r));
    arc_from = rev ? e_head_rd_r : e_tail_rd_r;
    arc_to   = rev ? e_tail_rd_r : e_head_rd_r;
    resid    = rev ? e_flow_rd_r : e_cap_rd_r - e_flow_rd_r;
    tsum     = TW'(total_r) + TW'(delta_r);
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    src_nxt = src_r;  dst_nxt = dst_r;  ncfg_nxt = ncfg_r;
    nodes_nxt = nodes_r;  v_nxt = v_r;  ecnt_nxt = ecnt_r;  ovf_nxt = ovf_r;
    id_nxt = id_r;  from_nxt = from_r;  u_nxt = u_r;  to_nxt = to_r;
    sum_nxt = sum_r;  k_nxt = k_r;  kend_nxt = kend_r;  qh_nxt = qh_r;  qt_nxt = qt_r;
    arc_nxt = arc_r;  resnz_nxt = resnz_r;  delta_nxt = delta_r;  total_nxt = total_r;
    ov_nxt = ov_r && !out_ready;  of_nxt = of_r;  od_nxt = od_r;

    e_we = 1'b0;  fl_we = 1'b0;  a_we = 1'b0;  f_we = 1'b0;
    p_we = 1'b0;  q_we = 1'b0;  r_we = 1'b0;
    e_wa  = ecnt_r[EAW-1:0];  e_ra = eidx(id_r[ARW-1:0], ecnt_r);
    fl_wa = ecnt_r[EAW-1:0];  fl_wd = '0;
    a_wa = f_rd_r[ARW-1:0];   a_wd = id_r[ARW-1:0];  a_ra = k_r[ARW-1:0];
    f_wa = v_r;  f_wd = '0;   f_ra = v_r;
    p_wa = NAW'(to_r);  p_wd = arc_r;  p_ra = NAW'(u_r);
    q_wa = qt_r[NAW-1:0];  q_wd = to_r;  q_ra = qh_r[NAW-1:0];
    r_wa = NAW'(to_r);  r_wd = 1'b1;  r_ra = NAW'(arc_to);

    if (cfg_write_en) begin
      case (cfg_index)
        ekmf_pkg::CFG_SOURCE: src_nxt  = cfg_data[NW-1:0];
        ekmf_pkg::CFG_SINK:   dst_nxt  = cfg_data[NW-1:0];
        ekmf_pkg::CFG_NODES:  ncfg_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ekmf_pkg::ACT_CLEAR: begin
              ecnt_nxt = '0;
              ovf_nxt  = 1'b0;
            end
            ekmf_pkg::ACT_ADD: begin
              if (32'(ecnt_r) >= 32'(MAX_EDGES)) begin
                ovf_nxt = 1'b1;
              end else begin
                e_we     = 1'b1;
                fl_we    = 1'b1;
                ecnt_nxt = ecnt_r + 1'b1;
              end
            end
            ekmf_pkg::ACT_COMPUTE: begin
              nodes_nxt = (32'(ncfg_r) > 32'(MAX_NODES)) ? FAW'(MAX_NODES) : FAW'(ncfg_r);
              state_nxt = S_CHK;
            end
            default: ;
          endcase
        end
      end
      S_CHK: begin
        total_nxt = '0;
        v_nxt     = '0;
        id_nxt    = '0;
        if (32'(src_r) >= 32'(nodes_r) || 32'(dst_r) >= 32'(nodes_r) || src_r == dst_r) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_FCLR;
        end
      end
      // zero the slot table
      S_FCLR: begin
        f_we = 1'b1;
        if (v_r == nodes_r) state_nxt = S_CRD;
        else v_nxt = v_r + 1'b1;
      end
      // count arcs per node; clear forward flows on the way
      S_CRD: begin
        if (id_r == arcs) begin
          v_nxt = '0;  sum_nxt = '0;  state_nxt = S_PRD;
        end else begin
          if (id_r < (ARW+1)'(ecnt_r)) begin
            fl_we = 1'b1;
            fl_wa = id_r[EAW-1:0];
          end
          arc_nxt   = id_r[ARW-1:0];
          state_nxt = S_CUS;
        end
      end
      S_CUS: begin
        from_nxt = arc_from;
        f_ra     = FAW'(arc_from) + 1'b1;
        if (usable) state_nxt = S_CWR;
        else begin
          id_nxt = id_r + 1'b1;  state_nxt = S_CRD;
        end
      end
      S_CWR: begin
        f_we = 1'b1;  f_wa = FAW'(from_r) + 1'b1;  f_wd = f_rd_r + 1'b1;
        id_nxt = id_r + 1'b1;  state_nxt = S_CRD;
      end
      // running sum over the counts
      S_PRD: state_nxt = S_PWR;
      S_PWR: begin
        f_we = 1'b1;  f_wd = sum_r + f_rd_r;  sum_nxt = sum_r + f_rd_r;
        if (v_r == nodes_r) begin
          id_nxt = '0;  state_nxt = S_LRD;
        end else begin
          v_nxt = v_r + 1'b1;  state_nxt = S_PRD;
        end
      end
      // place arc ids, forward then reverse, in id order
      S_LRD: begin
        if (id_r == arcs) begin
          v_nxt = nodes_r;  state_nxt = S_SRD;
        end else begin
          arc_nxt = id_r[ARW-1:0];  state_nxt = S_LUS;
        end
      end
      S_LUS: begin
        from_nxt = arc_from;
        f_ra     = FAW'(arc_from);
        if (usable) state_nxt = S_LWR;
        else begin
          id_nxt = id_r + 1'b1;  state_nxt = S_LRD;
        end
      end
      S_LWR: begin
        a_we = 1'b1;
        f_we = 1'b1;  f_wa = FAW'(from_r);  f_wd = f_rd_r + 1'b1;
        id_nxt = id_r + 1'b1;  state_nxt = S_LRD;
      end
      // shift cursors back up one node to recover the start slots
      S_SRD: begin
        f_ra = v_r - 1'b1;  state_nxt = S_SWR;
      end
      S_SWR: begin
        f_we = 1'b1;  f_wd = f_rd_r;
        if (v_r == FAW'(1)) state_nxt = S_SZ;
        else begin
          v_nxt = v_r - 1'b1;  state_nxt = S_SRD;
        end
      end
      S_SZ: begin
        f_we = 1'b1;  f_wa = '0;  f_wd = '0;
        v_nxt = '0;  state_nxt = S_BCLR;
      end
      // breadth-first search
      S_BCLR: begin
        r_we = 1'b1;  r_wa = v_r[NAW-1:0];  r_wd = 1'b0;
        if (v_r + 1'b1 == nodes_r) state_nxt = S_BINI;
        else v_nxt = v_r + 1'b1;
      end
      S_BINI: begin
        r_we = 1'b1;  r_wa = NAW'(src_r);
        q_we = 1'b1;  q_wa = '0;  q_wd = src_r;
        qh_nxt = '0;  qt_nxt = FAW'(1);  state_nxt = S_BDEQ;
      end
      S_BDEQ: begin
        if (qh_r == qt_r) state_nxt = S_FIN;
        else begin
          qh_nxt = qh_r + 1'b1;  state_nxt = S_BU;
        end
      end
      S_BU: begin
        u_nxt = q_rd_r;  f_ra = FAW'(q_rd_r);  state_nxt = S_BB;
      end
      S_BB: begin
        k_nxt = f_rd_r;  f_ra = FAW'(u_r) + 1'b1;  state_nxt = S_BE;
      end
      S_BE: begin
        kend_nxt = f_rd_r;  state_nxt = S_BADJ;
      end
      S_BADJ: begin
        if (k_r == kend_r) state_nxt = S_BDEQ;
        else state_nxt = S_BARC;
      end
      S_BARC: begin
        arc_nxt = a_rd_r;  e_ra = eidx(a_rd_r, ecnt_r);  state_nxt = S_BEV;
      end
      S_BEV: begin
        to_nxt = arc_to;  resnz_nxt = (resid != '0);  state_nxt = S_BCHK;
      end
      S_BCHK: begin
        k_nxt     = k_r + 1'b1;
        state_nxt = S_BADJ;
        if (!r_rd_r && resnz_r) begin
          r_we = 1'b1;  p_we = 1'b1;  q_we = 1'b1;
          qt_nxt = qt_r + 1'b1;
          if (to_r == dst_r) begin
            u_nxt = dst_r;  delta_nxt = '1;  state_nxt = S_P1R;
          end
        end
      end
      // bottleneck walk, sink back to source
      S_P1R: begin
        if (u_r == src_r) begin
          u_nxt = dst_r;  state_nxt = S_P2R;
        end else state_nxt = S_P1E;
      end
      S_P1E: begin
        arc_nxt = p_rd_r;  e_ra = eidx(p_rd_r, ecnt_r);  state_nxt = S_P1C;
      end
      S_P1C: begin
        if (resid < delta_r) delta_nxt = resid;
        u_nxt = arc_from;  state_nxt = S_P1R;
      end
      // push walk
      S_P2R: begin
        if (u_r == src_r) begin
          total_nxt = (tsum > TW'(ekmf_pkg::FLOW_LIMIT)) ? ekmf_pkg::FLOW_LIMIT
                                                          : tsum[ekmf_pkg::FLOW_W-1:0];
          v_nxt = '0;  state_nxt = S_BCLR;
        end else state_nxt = S_P2E;
      end
      S_P2E: begin
        arc_nxt = p_rd_r;  e_ra = eidx(p_rd_r, ecnt_r);  state_nxt = S_P2W;
      end
      S_P2W: begin
        fl_we = 1'b1;  fl_wa = eidx(arc_r, ecnt_r);
        fl_wd = rev ? e_flow_rd_r - delta_r : e_flow_rd_r + delta_r;
        u_nxt = arc_from;  state_nxt = S_P2R;
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;  of_nxt = total_r;  od_nxt = ovf_r;  state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      src_r   <= '0;
      dst_r   <= NW'(1);
      ncfg_r  <= 11'd1024;
      ecnt_r  <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      ncfg_r  <= ncfg_nxt;
      ecnt_r  <= ecnt_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nodes_r <= nodes_nxt;  v_r <= v_nxt;  id_r <= id_nxt;
    from_r <= from_nxt;  u_r <= u_nxt;  to_r <= to_nxt;
    sum_r <= sum_nxt;  k_r <= k_nxt;  kend_r <= kend_nxt;
    qh_r <= qh_nxt;  qt_r <= qt_nxt;  arc_r <= arc_nxt;  resnz_r <= resnz_nxt;
    delta_r <= delta_nxt;  total_r <= total_nxt;  of_r <= of_nxt;  od_r <= od_nxt;
  end

  assign out_valid         = ov_r;
  assign out_max_flow      = of_r;
  assign out_edges_dropped = od_r;

endmodule

/* rtl/ekmf_checker.sv */
module ekmf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  in_action,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ekmf_pkg::FLOW_W-1:0] out_max_flow
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_flow))
    else $error("stalled result changed");

  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ekmf_pkg::ACT_COMPUTE |=> !in_ready)
    else $error("compute request did not occupy the block");

  a_add_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ekmf_pkg::ACT_ADD ||
                             in_action == ekmf_pkg::ACT_CLEAR) |=> in_ready)
    else $error("table request took more than one cycle");

endmodule

bind edmonds_karp_max_flow ekmf_checker u_ekmf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_action    (in_action),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_max_flow (out_max_flow)
);
